// ===== design/pts_pkg.sv =====
package pts_pkg;

    // Field widths fixed by the interface.
    localparam int CLK_W      = 28;
    localparam int TONE_W     = 20;
    localparam int SLOT_W     = 6;
    localparam int LEN_IN_W   = 16;
    localparam int SEQ_LEN_W  = 7;
    localparam int SHIFT_W    = 4;
    localparam int WRAP_W     = 16;
    localparam int CMP_W      = 15;
    localparam int NOTE_W     = 6;
    localparam int DIV_CNT_W  = $clog2(CLK_W + 1);

    localparam logic [CLK_W-1:0]   CLK_HZ_RESET = 28'd125000000;
    // A quotient above this value gives a wrap that does not fit 16 bits.
    localparam logic [CLK_W-1:0]   WRAP_LIMIT   = 28'd65536;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT    = 4'd8;
    localparam logic [WRAP_W-1:0]  WRAP_MAX     = 16'hFFFF;
    localparam logic [WRAP_W-1:0]  WRAP_MIN     = 16'd1;

    localparam int DEF_MAX_NOTES     = 64;
    localparam int DEF_MAX_LENGTH_MS = 1000;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_START = 3'd2,
        OP_TONE  = 3'd3,
        OP_STOP  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TONE,
        ST_DIV,
        ST_NORM,
        ST_DONE
    } t_state;

endpackage

// ===== design/pwm_tone_sequencer.sv =====
// Buzzer tone sequencer. Every input beat gives exactly one output beat that
// shows the PWM settings and playback state after that beat. Ticks that do
// not move to the next note, loads, stops and ignored codes go straight to the
// done state and reach the output register once it is free. A nonempty sequence
// start or a tick that moves to the next note first reads the note table.
// Starting a tone then runs a 28-step serial division of the system clock by
// the tone frequency, followed by up to 8 divider shift steps; a zero frequency
// skips the division and leaves the buzzer silent.
// A new beat is accepted once the previous result sits in the output
// register, even if the sink still stalls it. The note table is a 64-entry
// synchronous memory with no reset; play only slots that have been loaded.
module pwm_tone_sequencer #(
    parameter int MAX_NOTES     = pts_pkg::DEF_MAX_NOTES,
    parameter int MAX_LENGTH_MS = pts_pkg::DEF_MAX_LENGTH_MS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pts_pkg::CLK_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_op,
    input  logic [pts_pkg::SLOT_W-1:0]    i_note_slot,
    input  logic [pts_pkg::TONE_W-1:0]    i_tone_hz,
    input  logic [pts_pkg::LEN_IN_W-1:0]  i_length_ms,
    input  logic [pts_pkg::SEQ_LEN_W-1:0] i_sequence_length,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_pwm_on,
    output logic [pts_pkg::SHIFT_W-1:0]   o_divider_shift,
    output logic [pts_pkg::WRAP_W-1:0]    o_period_wrap,
    output logic [pts_pkg::CMP_W-1:0]     o_compare_level,
    output logic                          o_is_playing,
    output logic                          o_in_sequence,
    output logic [pts_pkg::NOTE_W-1:0]    o_current_note
);

    localparam int AW  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CW  = $clog2(MAX_NOTES + 1);
    localparam int CW1 = CW + 1;
    localparam int LW  = $clog2(MAX_LENGTH_MS + 1);
    localparam int MW  = pts_pkg::TONE_W + LW;

    pts_pkg::t_state                r_state, n_state;
    logic [pts_pkg::CLK_W-1:0]      r_clk_hz;
    logic [pts_pkg::TONE_W-1:0]     r_hz, n_hz;
    logic [LW-1:0]                  r_len, n_len;
    logic [CW-1:0]                  r_count, n_count;
    logic [AW-1:0]                  r_pos, n_pos;
    logic                           r_seq, n_seq;
    logic                           r_play, n_play;
    logic                           r_timed, n_timed;
    logic [LW-1:0]                  r_rem, n_rem;
    logic [pts_pkg::SHIFT_W-1:0]    r_shift, n_shift;
    logic [pts_pkg::WRAP_W-1:0]     r_wrap, n_wrap;
    logic [pts_pkg::CLK_W-1:0]      r_q, n_q;
    logic                           r_out_valid;

    logic                           r_o_pwm_on;
    logic [pts_pkg::SHIFT_W-1:0]    r_o_shift;
    logic [pts_pkg::WRAP_W-1:0]     r_o_wrap;
    logic                           r_o_seq;
    logic [pts_pkg::NOTE_W-1:0]     r_o_note;

    logic [MW-1:0]                  mem [MAX_NOTES];
    logic [MW-1:0]                  r_rd_data;

    logic                           w_accept;
    pts_pkg::t_op                   w_op;
    logic [LW-1:0]                  w_rem_dec;
    logic                           w_advance;
    logic [CW-1:0]                  w_cnt_sat;
    logic [LW-1:0]                  w_len_clamp;
    logic                           w_norm_step;
    logic [pts_pkg::WRAP_W-1:0]     w_wrap_fin;
    logic                           w_mem_we;
    logic [AW-1:0]                  w_rd_addr;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [pts_pkg::CLK_W-1:0]      w_quotient;
    logic                           w_out_load;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_op      = pts_pkg::t_op'(i_op);
    assign w_rem_dec = (r_rem != '0) ? r_rem - LW'(1) : r_rem;
    assign w_advance = r_seq && ((CW1'(r_pos) + CW1'(1)) < CW1'(r_count));
    assign w_cnt_sat = (32'(i_sequence_length) > 32'(MAX_NOTES)) ?
                       CW'(MAX_NOTES) : CW'(i_sequence_length);
    assign w_len_clamp = (32'(i_length_ms) > 32'(MAX_LENGTH_MS)) ?
                         LW'(MAX_LENGTH_MS) : LW'(i_length_ms);
    assign w_norm_step = (r_q > pts_pkg::WRAP_LIMIT) && (r_shift < pts_pkg::MAX_SHIFT);

    always_comb begin
        if (r_q <= pts_pkg::CLK_W'(1)) begin
            w_wrap_fin = pts_pkg::WRAP_MIN;
        end else if (r_q > pts_pkg::WRAP_LIMIT) begin
            w_wrap_fin = pts_pkg::WRAP_MAX;
        end else begin
            w_wrap_fin = pts_pkg::WRAP_W'(r_q - pts_pkg::CLK_W'(1));
        end
    end

    pts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_clk_hz),
        .i_divisor  (r_hz),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pts_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        pts_pkg::OP_TICK: begin
                            n_state = (r_timed && w_rem_dec == '0 && w_advance) ?
                                      pts_pkg::ST_READ : pts_pkg::ST_DONE;
                        end
                        pts_pkg::OP_START: begin
                            n_state = (i_sequence_length != '0) ?
                                      pts_pkg::ST_READ : pts_pkg::ST_DONE;
                        end
                        pts_pkg::OP_TONE: n_state = pts_pkg::ST_TONE;
                        default:          n_state = pts_pkg::ST_DONE;
                    endcase
                end
            end
            pts_pkg::ST_READ: n_state = pts_pkg::ST_TONE;
            pts_pkg::ST_TONE: begin
                n_state = (r_hz == '0) ? pts_pkg::ST_DONE : pts_pkg::ST_DIV;
            end
            pts_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = pts_pkg::ST_NORM;
                end
            end
            pts_pkg::ST_NORM: begin
                if (!w_norm_step) begin
                    n_state = pts_pkg::ST_DONE;
                end
            end
            pts_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_state = pts_pkg::ST_IDLE;
                end
            end
            default: n_state = pts_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the state machine.
    always_comb begin
        o_in_stall  = (r_state != pts_pkg::ST_IDLE);
        w_mem_we    = w_accept && (w_op == pts_pkg::OP_LOAD) &&
                      (32'(i_note_slot) < 32'(MAX_NOTES));
        w_rd_addr   = (w_op == pts_pkg::OP_START) ? '0 : r_pos + AW'(1);
        w_div_start = (r_state == pts_pkg::ST_TONE) && (r_hz != '0);
        w_out_load  = (r_state == pts_pkg::ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    // Datapath.
    always_comb begin
        n_hz    = r_hz;
        n_len   = r_len;
        n_count = r_count;
        n_pos   = r_pos;
        n_seq   = r_seq;
        n_play  = r_play;
        n_timed = r_timed;
        n_rem   = r_rem;
        n_shift = r_shift;
        n_wrap  = r_wrap;
        n_q     = r_q;
        case (r_state)
            pts_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        pts_pkg::OP_TICK: begin
                            if (r_timed) begin
                                n_rem = w_rem_dec;
                                if (w_rem_dec == '0) begin
                                    if (w_advance) begin
                                        n_pos = r_pos + AW'(1);
                                    end else begin
                                        n_play  = 1'b0;
                                        n_shift = '0;
                                        n_wrap  = '0;
                                        n_timed = 1'b0;
                                        n_rem   = '0;
                                        n_seq   = 1'b0;
                                        n_count = '0;
                                        n_pos   = '0;
                                    end
                                end
                            end
                        end
                        pts_pkg::OP_START: begin
                            if (i_sequence_length != '0) begin
                                n_seq   = 1'b1;
                                n_count = w_cnt_sat;
                                n_pos   = '0;
                            end
                        end
                        pts_pkg::OP_TONE: begin
                            n_seq   = 1'b0;
                            n_count = '0;
                            n_pos   = '0;
                            n_hz    = i_tone_hz;
                            n_len   = w_len_clamp;
                        end
                        pts_pkg::OP_STOP: begin
                            n_play  = 1'b0;
                            n_shift = '0;
                            n_wrap  = '0;
                            n_timed = 1'b0;
                            n_rem   = '0;
                            n_seq   = 1'b0;
                            n_count = '0;
                            n_pos   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            pts_pkg::ST_READ: begin
                n_hz  = r_rd_data[MW-1:LW];
                n_len = r_rd_data[LW-1:0];
            end
            pts_pkg::ST_TONE: begin
                n_timed = (r_len != '0);
                n_rem   = r_len;
                if (r_hz == '0) begin
                    n_play  = 1'b0;
                    n_shift = '0;
                    n_wrap  = '0;
                end
            end
            pts_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_q     = w_quotient;
                    n_shift = '0;
                end
            end
            pts_pkg::ST_NORM: begin
                // Dividing by a further power of two is a shift of the quotient.
                if (w_norm_step) begin
                    n_q     = r_q >> 1;
                    n_shift = r_shift + pts_pkg::SHIFT_W'(1);
                end else begin
                    n_wrap = w_wrap_fin;
                    n_play = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pts_pkg::ST_IDLE;
            r_clk_hz    <= pts_pkg::CLK_HZ_RESET;
            r_count     <= '0;
            r_pos       <= '0;
            r_seq       <= 1'b0;
            r_play      <= 1'b0;
            r_timed     <= 1'b0;
            r_rem       <= '0;
            r_shift     <= '0;
            r_wrap      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_data;
            end
            r_count <= n_count;
            r_pos   <= n_pos;
            r_seq   <= n_seq;
            r_play  <= n_play;
            r_timed <= n_timed;
            r_rem   <= n_rem;
            r_shift <= n_shift;
            r_wrap  <= n_wrap;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hz  <= n_hz;
        r_len <= n_len;
        r_q   <= n_q;
        if (w_out_load) begin
            r_o_pwm_on <= r_play;
            r_o_shift  <= r_play ? r_shift : '0;
            r_o_wrap   <= r_play ? r_wrap : '0;
            r_o_seq    <= r_seq;
            r_o_note   <= r_seq ? pts_pkg::NOTE_W'(r_pos) : '0;
        end
    end

    // Note table: frequency in the upper bits, clamped length in the lower.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[AW'(i_note_slot)] <= {i_tone_hz, w_len_clamp};
        end
        r_rd_data <= mem[w_rd_addr];
    end

    assign o_out_valid     = r_out_valid;
    assign o_pwm_on        = r_o_pwm_on;
    assign o_divider_shift = r_o_shift;
    assign o_period_wrap   = r_o_wrap;
    assign o_compare_level = r_o_wrap[pts_pkg::WRAP_W-1:1];
    assign o_is_playing    = r_o_pwm_on;
    assign o_in_sequence   = r_o_seq;
    assign o_current_note  = r_o_note;

endmodule

// ===== design/pts_div.sv =====
module pts_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pts_pkg::CLK_W-1:0]  i_dividend,
    input  logic [pts_pkg::TONE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pts_pkg::CLK_W-1:0]  o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [pts_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [pts_pkg::TONE_W-1:0]     r_rem;
    logic [pts_pkg::CLK_W-1:0]      r_quo;
    logic [pts_pkg::TONE_W-1:0]     r_div;
    logic [pts_pkg::TONE_W:0]       w_trial;
    logic [pts_pkg::TONE_W:0]       w_diff;
    logic                           w_fits;

    // One quotient bit per cycle, restoring form.
    assign w_trial = {r_rem, r_quo[pts_pkg::CLK_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pts_pkg::DIV_CNT_W'(pts_pkg::CLK_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - pts_pkg::DIV_CNT_W'(1);
                if (r_cnt == pts_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[pts_pkg::TONE_W-1:0] : w_trial[pts_pkg::TONE_W-1:0];
            r_quo <= {r_quo[pts_pkg::CLK_W-2:0], w_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/pts_checker.sv =====
module pts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_pwm_on,
    input logic [pts_pkg::SHIFT_W-1:0]   o_divider_shift,
    input logic [pts_pkg::WRAP_W-1:0]    o_period_wrap,
    input logic [pts_pkg::CMP_W-1:0]     o_compare_level,
    input logic                          o_is_playing,
    input logic                          o_in_sequence,
    input logic [pts_pkg::NOTE_W-1:0]    o_current_note
);

    // A stalled result beat stays valid with its wrap, PWM flag, note and sequence flag unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_period_wrap) && $stable(o_pwm_on) &&
            $stable(o_current_note) && $stable(o_in_sequence))
        else $error("output beat changed while stalled");

    // While silent, every PWM setting reads as zero.
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pwm_on |->
            o_divider_shift == '0 && o_period_wrap == '0 && o_compare_level == '0 &&
            !o_is_playing)
        else $error("silent beat carries PWM settings");

    // A sounding tone has a legal wrap, divider and half-wrap compare level.
    a_tone_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pwm_on |->
            o_period_wrap != '0 && o_divider_shift <= pts_pkg::MAX_SHIFT &&
            o_compare_level == o_period_wrap[pts_pkg::WRAP_W-1:1] && o_is_playing)
        else $error("inconsistent tone settings");

    // The note index reads zero outside a sequence.
    a_note_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_sequence |-> o_current_note == '0)
        else $error("note index set outside a sequence");

endmodule

bind pwm_tone_sequencer pts_checker u_pts_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_PCT     = 21;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BEATS  = 137;
    localparam int NUM_PHASES   = 7;
    localparam int TAIL_CYCLES  = 60;
    localparam int LIMIT_CYCLES = 800000;
    localparam int NOTE_SLOTS   = pts_pkg::DEF_MAX_NOTES;
    localparam int REPORT_MAX   = 10;

    // Codes 5 to 7 are not assigned to any operation.
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic                        pwm_on;
        logic [pts_pkg::SHIFT_W-1:0] shift;
        logic [pts_pkg::WRAP_W-1:0]  wrap;
        logic [pts_pkg::CMP_W-1:0]   cmp;
        logic                        playing;
        logic                        in_seq;
        logic [pts_pkg::NOTE_W-1:0]  note;
    } t_pwm_result;

    typedef struct packed {
        logic [2:0]                    op;
        logic [pts_pkg::SLOT_W-1:0]    slot;
        logic [pts_pkg::TONE_W-1:0]    hz;
        logic [pts_pkg::LEN_IN_W-1:0]  ms;
        logic [pts_pkg::SEQ_LEN_W-1:0] cnt;
        logic                          has_exp;
        t_pwm_result                   exp;
    } t_stim_row;

    localparam t_pwm_result SILENT = '0;

    localparam int DIR_ROWS = 25;
    localparam t_stim_row DIRECTED [DIR_ROWS] = '{
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b1, SILENT},
        '{OP_RSVD_LAST,      6'd0,  20'd0,     16'd0,    7'd0, 1'b1, SILENT},
        '{pts_pkg::OP_STOP,  6'd0,  20'd0,     16'd0,    7'd0, 1'b1, SILENT},
        '{pts_pkg::OP_LOAD,  6'd0,  20'd440,   16'd3,    7'd0, 1'b1, SILENT},
        '{pts_pkg::OP_LOAD,  6'd1,  20'd0,     16'd2,    7'd0, 1'b1, SILENT},
        '{pts_pkg::OP_LOAD,  6'd2,  20'hFFFFF, 16'd2,    7'd0, 1'b1, SILENT},
        '{pts_pkg::OP_LOAD,  6'd3,  20'd1,     16'd1,    7'd0, 1'b1, SILENT},
        '{pts_pkg::OP_LOAD,  6'd63, 20'd2000,  16'hFFFF, 7'd0, 1'b1, SILENT},
        '{pts_pkg::OP_START, 6'd0,  20'd0,     16'd0,    7'd0, 1'b1, SILENT},
        '{pts_pkg::OP_START, 6'd0,  20'd0,     16'd0,    7'd4, 1'b0, SILENT},
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TONE,  6'd0,  20'd1,     16'hFFFF, 7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TONE,  6'd0,  20'd0,     16'd5,    7'd0, 1'b1, SILENT},
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TONE,  6'd0,  20'd440,   16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_TICK,  6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{OP_RSVD_FIRST,     6'd0,  20'd0,     16'd0,    7'd0, 1'b0, SILENT},
        '{pts_pkg::OP_STOP,  6'd0,  20'd0,     16'd0,    7'd0, 1'b1, SILENT}
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [pts_pkg::CLK_W-1:0]     i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [2:0]                    i_op;
    logic [pts_pkg::SLOT_W-1:0]    i_note_slot;
    logic [pts_pkg::TONE_W-1:0]    i_tone_hz;
    logic [pts_pkg::LEN_IN_W-1:0]  i_length_ms;
    logic [pts_pkg::SEQ_LEN_W-1:0] i_sequence_length;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic                          o_pwm_on;
    logic [pts_pkg::SHIFT_W-1:0]   o_divider_shift;
    logic [pts_pkg::WRAP_W-1:0]    o_period_wrap;
    logic [pts_pkg::CMP_W-1:0]     o_compare_level;
    logic                          o_is_playing;
    logic                          o_in_sequence;
    logic [pts_pkg::NOTE_W-1:0]    o_current_note;

    pwm_tone_sequencer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_note_slot       (i_note_slot),
        .i_tone_hz         (i_tone_hz),
        .i_length_ms       (i_length_ms),
        .i_sequence_length (i_sequence_length),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_pwm_on          (o_pwm_on),
        .o_divider_shift   (o_divider_shift),
        .o_period_wrap     (o_period_wrap),
        .o_compare_level   (o_compare_level),
        .o_is_playing      (o_is_playing),
        .o_in_sequence     (o_in_sequence),
        .o_current_note    (o_current_note)
    );

    // Shadow copy of the sequencer state.
    logic [pts_pkg::TONE_W-1:0]    tone_tbl [NOTE_SLOTS];
    logic [9:0]                    len_tbl  [NOTE_SLOTS];
    bit                            slot_loaded [NOTE_SLOTS];
    logic [pts_pkg::SEQ_LEN_W-1:0] seq_notes;
    logic [pts_pkg::NOTE_W-1:0]    seq_pos;
    logic                          seq_active;
    logic                          sounding;
    logic                          timed;
    logic [9:0]                    ms_left;
    logic [pts_pkg::SHIFT_W-1:0]   shift_q;
    logic [pts_pkg::WRAP_W-1:0]    wrap_q;
    logic [pts_pkg::CLK_W-1:0]     clk_hz_q;

    t_pwm_result pending_pwm [$];
    int          fail_count;
    int          beats_seen;
    int          cycles;
    bit          calm;
    bit          hold_req;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic longint unsigned wrap_for(input logic [pts_pkg::TONE_W-1:0] hz,
                                                 input int unsigned s);
        longint unsigned den;
        longint unsigned q;
        den = hz;
        den = den << s;
        q = clk_hz_q / den;
        return (q == 0) ? 0 : q - 1;
    endfunction

    function automatic string fmt_result(input t_pwm_result r);
        return $sformatf("on=%0d shift=%0d wrap=%0d cmp=%0d play=%0d seq=%0d note=%0d",
                         r.pwm_on, r.shift, r.wrap, r.cmp, r.playing, r.in_seq, r.note);
    endfunction

    task automatic begin_tone(input logic [pts_pkg::TONE_W-1:0] hz,
                              input logic [pts_pkg::LEN_IN_W-1:0] ms);
        logic [9:0]      len;
        int unsigned     s;
        longint unsigned w;
        len = (ms > pts_pkg::DEF_MAX_LENGTH_MS) ? 10'(pts_pkg::DEF_MAX_LENGTH_MS) : ms[9:0];
        if (hz == 0) begin
            sounding = 1'b0;
            shift_q  = '0;
            wrap_q   = '0;
        end else begin
            s = 0;
            w = wrap_for(hz, 0);
            while (w > pts_pkg::WRAP_MAX && s < pts_pkg::MAX_SHIFT) begin
                s++;
                w = wrap_for(hz, s);
            end
            if (w > pts_pkg::WRAP_MAX) w = pts_pkg::WRAP_MAX;
            if (w < pts_pkg::WRAP_MIN) w = pts_pkg::WRAP_MIN;
            shift_q  = s[pts_pkg::SHIFT_W-1:0];
            wrap_q   = w[pts_pkg::WRAP_W-1:0];
            sounding = 1'b1;
        end
        timed   = (len != 0);
        ms_left = len;
    endtask

    task automatic halt_playback();
        sounding   = 1'b0;
        shift_q    = '0;
        wrap_q     = '0;
        timed      = 1'b0;
        ms_left    = '0;
        seq_active = 1'b0;
        seq_notes  = '0;
        seq_pos    = '0;
    endtask

    task automatic predict_pwm_settings(input logic [2:0] op,
                                        input logic [pts_pkg::SLOT_W-1:0] slot,
                                        input logic [pts_pkg::TONE_W-1:0] hz,
                                        input logic [pts_pkg::LEN_IN_W-1:0] ms,
                                        input logic [pts_pkg::SEQ_LEN_W-1:0] cnt,
                                        output t_pwm_result r);
        logic [pts_pkg::SEQ_LEN_W-1:0] n;
        case (op)
            pts_pkg::OP_TICK: begin
                if (timed) begin
                    if (ms_left > 0) ms_left--;
                    if (ms_left == 0) begin
                        if (seq_active && ({1'b0, seq_pos} + 7'd1) < seq_notes) begin
                            seq_pos++;
                            begin_tone(tone_tbl[seq_pos],
                                       pts_pkg::LEN_IN_W'(len_tbl[seq_pos]));
                        end else begin
                            halt_playback();
                        end
                    end
                end
            end
            pts_pkg::OP_LOAD: begin
                tone_tbl[slot]    = hz;
                len_tbl[slot]     = (ms > pts_pkg::DEF_MAX_LENGTH_MS) ?
                                    10'(pts_pkg::DEF_MAX_LENGTH_MS) : ms[9:0];
                slot_loaded[slot] = 1'b1;
            end
            pts_pkg::OP_START: begin
                if (cnt != 0) begin
                    n = (cnt > NOTE_SLOTS) ? pts_pkg::SEQ_LEN_W'(NOTE_SLOTS) : cnt;
                    seq_active = 1'b1;
                    seq_notes  = n;
                    seq_pos    = '0;
                    begin_tone(tone_tbl[0], pts_pkg::LEN_IN_W'(len_tbl[0]));
                end
            end
            pts_pkg::OP_TONE: begin
                seq_active = 1'b0;
                seq_notes  = '0;
                seq_pos    = '0;
                begin_tone(hz, ms);
            end
            pts_pkg::OP_STOP: halt_playback();
            default: ;
        endcase
        r.pwm_on  = sounding;
        r.shift   = sounding ? shift_q : '0;
        r.wrap    = sounding ? wrap_q : '0;
        r.cmp     = sounding ? wrap_q[pts_pkg::WRAP_W-1:1] : '0;
        r.playing = sounding;
        r.in_seq  = seq_active;
        r.note    = seq_active ? seq_pos : '0;
    endtask

    function automatic logic [pts_pkg::TONE_W-1:0] rand_hz();
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 25) return pts_pkg::TONE_W'($urandom_range(40, 1));
        if (r < 60) return pts_pkg::TONE_W'($urandom_range(5000, 100));
        return pts_pkg::TONE_W'($urandom);
    endfunction

    function automatic logic [pts_pkg::LEN_IN_W-1:0] rand_ms();
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 70) return pts_pkg::LEN_IN_W'($urandom_range(4, 1));
        if (r < 90) return pts_pkg::LEN_IN_W'($urandom_range(40, 5));
        return pts_pkg::LEN_IN_W'($urandom);
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic [2:0] op,
                             input logic [pts_pkg::SLOT_W-1:0] slot,
                             input logic [pts_pkg::TONE_W-1:0] hz,
                             input logic [pts_pkg::LEN_IN_W-1:0] ms,
                             input logic [pts_pkg::SEQ_LEN_W-1:0] cnt,
                             input logic has_exp,
                             input t_pwm_result typed);
        t_pwm_result r;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_op              <= op;
        i_note_slot       <= slot;
        i_tone_hz         <= hz;
        i_length_ms       <= ms;
        i_sequence_length <= cnt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_pwm_settings(op, slot, hz, ms, cnt, r);
        pending_pwm.push_back(has_exp ? typed : r);
    endtask

    task automatic random_beat();
        logic [2:0]                    op;
        logic [pts_pkg::SEQ_LEN_W-1:0] cnt;
        int                            r;
        int                            prefix;
        r = $urandom_range(99);
        if (r < 50)      op = pts_pkg::OP_TICK;
        else if (r < 62) op = pts_pkg::OP_LOAD;
        else if (r < 74) op = pts_pkg::OP_START;
        else if (r < 86) op = pts_pkg::OP_TONE;
        else if (r < 93) op = pts_pkg::OP_STOP;
        else             op = 3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
        cnt = pts_pkg::SEQ_LEN_W'($urandom);
        // A sequence may only walk over slots that have been loaded.
        prefix = 0;
        while (prefix < NOTE_SLOTS && slot_loaded[prefix]) prefix++;
        if (op == pts_pkg::OP_START && prefix < NOTE_SLOTS)
            cnt = pts_pkg::SEQ_LEN_W'($urandom_range(prefix, 0));
        send_beat(op, pts_pkg::SLOT_W'($urandom), rand_hz(), rand_ms(), cnt, 1'b0, SILENT);
    endtask

    task automatic write_clock(input logic [pts_pkg::CLK_W-1:0] hz);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= hz;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        clk_hz_q = hz;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Output side: check each accepted beat, then pick the next stall value.
    always @(posedge i_clk) begin : out_side
        t_pwm_result got;
        t_pwm_result want;
        int          hold_left;
        got = {o_pwm_on, o_divider_shift, o_period_wrap, o_compare_level,
               o_is_playing, o_in_sequence, o_current_note};
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_seen++;
            if (pending_pwm.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("output beat %0d arrived with nothing expected", beats_seen);
            end else begin
                want = pending_pwm.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("output beat %0d: expected %s, got %s", beats_seen,
                                 fmt_result(want), fmt_result(got));
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial begin : stimulus
        logic [pts_pkg::CLK_W-1:0] phase_clk [NUM_PHASES];
        int                        k;
        int                        ph;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_op              <= pts_pkg::OP_TICK;
        i_note_slot       <= '0;
        i_tone_hz         <= '0;
        i_length_ms       <= '0;
        i_sequence_length <= '0;
        i_out_stall       <= 1'b0;
        fail_count = 0;
        beats_seen = 0;
        cycles     = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        clk_hz_q   = pts_pkg::CLK_HZ_RESET;
        for (k = 0; k < NOTE_SLOTS; k++) slot_loaded[k] = 1'b0;
        halt_playback();

        phase_clk[0] = 28'd250000000;
        phase_clk[1] = 28'd1000000;
        phase_clk[2] = '0;
        phase_clk[3] = '1;
        phase_clk[4] = pts_pkg::CLK_W'($urandom_range(250000000, 1000000));
        phase_clk[5] = pts_pkg::CLK_W'($urandom_range(250000000, 1000000));
        phase_clk[6] = pts_pkg::CLK_HZ_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++)
            send_beat(DIRECTED[k].op, DIRECTED[k].slot, DIRECTED[k].hz, DIRECTED[k].ms,
                      DIRECTED[k].cnt, DIRECTED[k].has_exp, DIRECTED[k].exp);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            i_in_valid <= 1'b0;
            while (pending_pwm.size() != 0) @(posedge i_clk);
            write_clock(phase_clk[ph]);
            // Fill the whole note table so later sequences can run to any length.
            if (ph == 0)
                for (k = 0; k < NOTE_SLOTS; k++)
                    send_beat(pts_pkg::OP_LOAD, pts_pkg::SLOT_W'(k), rand_hz(), rand_ms(),
                              pts_pkg::SEQ_LEN_W'($urandom), 1'b0, SILENT);
            for (k = 0; k < PHASE_BEATS; k++) begin
                if (ph == 1 && k == 40) hold_req = 1'b1;
                calm = (ph == 2 && k < 100);
                random_beat();
            end
            calm = 1'b0;
        end

        i_in_valid <= 1'b0;
        while (pending_pwm.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_pwm.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pts_pkg.sv
design/pts_div.sv
design/pwm_tone_sequencer.sv
design/pts_checker.sv
sim/tb.sv
